FILE: rtl/mhpq_pkg.sv
// shared types and constants of the min-heap priority queue
// no dependencies; compile first
package mhpq_pkg;

    // field widths
    localparam int KEY_W          = 32;
    localparam int TAG_W          = 8;
    localparam int OCC_W          = 6;

    // default heap size
    localparam int HEAP_DEPTH_DEF = 32;

    // action codes
    localparam logic ACT_INSERT   = 1'b0;
    localparam logic ACT_EXTRACT  = 1'b1;

    // one heap slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

FILE: rtl/mhpq_if.sv
// request and response channel interfaces of the min-heap priority queue
// depends on mhpq_pkg

// request channel: one operation per transaction
interface mhpq_in_if;
    import mhpq_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] entry_key;
    logic [TAG_W-1:0] entry_tag;

    modport source (output valid, action, entry_key, entry_tag, input ready);
    modport sink   (input valid, action, entry_key, entry_tag, output ready);
endinterface

// response channel: one result per request
interface mhpq_out_if;
    import mhpq_pkg::*;

    logic             valid;
    logic             ready;
    logic             out_valid;
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic             dropped;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, out_valid, out_key, out_tag, dropped, occupancy,
                    input ready);
    modport sink   (input valid, out_valid, out_key, out_tag, dropped, occupancy,
                    output ready);
endinterface

FILE: rtl/mhpq_ram.sv
// generic ram: one write port, two registered read ports
// no dependencies
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: rtl/min_heap_priority_queue.sv
// min-heap priority queue: top level with sift sequencer and result register
// depends on mhpq_pkg, mhpq_if, mhpq_ram
//
//  port   dir  transaction     payload
//  i_in   in   valid & ready   action, entry_key, entry_tag
//  o_out  out  valid & ready   out_valid, out_key, out_tag, dropped, occupancy
//
// one operation at a time; one key compare per heap level, each made on data
// from the registered read of the slot ram
// insert: sifts up from the new last slot while its key is below the parent key
// extract: returns the root and sifts the last slot down while a child key is smaller
// dropped inserts (heap full) and empty extracts go straight to the result
// synchronous active-low reset clears the entry count and control; slots need no clear
// a result waits in the output register while the next request is accepted
module min_heap_priority_queue #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mhpq_in_if.sink  i_in,
    mhpq_out_if.source o_out
);
    import mhpq_pkg::*;

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = AW + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_ROOT = 3'd3;
    localparam logic [2:0] S_DN_RD   = 3'd4;
    localparam logic [2:0] S_DN_CMP  = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_pos, n_pos;
    t_entry           r_item, n_item;
    logic             r_res_valid, n_res_valid;
    t_entry           r_res, n_res;
    logic             r_res_drop, n_res_drop;
    logic             r_out_full, n_out_full;
    logic             r_out_valid, n_out_valid;
    t_entry           r_out, n_out;
    logic             r_out_drop, n_out_drop;
    logic [OCC_W-1:0] r_out_occ, n_out_occ;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_entry           w_wdata;
    logic [AW-1:0]    w_raddr_a;
    logic [AW-1:0]    w_raddr_b;
    t_entry           w_rdata_a;
    t_entry           w_rdata_b;

    logic             w_in_acc;
    logic [AW-1:0]    w_parent;
    logic [LW-1:0]    w_lc;
    logic [LW-1:0]    w_rc;
    logic [LW-1:0]    w_count_l;
    logic             w_take_l;
    logic             w_take_r;
    logic [KEY_W-1:0] w_best_key;

    // slot storage
    mhpq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (HEAP_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    // heap index arithmetic
    assign w_parent  = AW'((r_pos - AW'(1)) >> 1);
    assign w_lc      = {1'b0, r_pos, 1'b1};
    assign w_rc      = LW'(w_lc + LW'(1));
    assign w_count_l = LW'(r_count);

    // child selection; left child wins a tie
    always_comb begin
        w_take_l   = 1'b0;
        w_take_r   = 1'b0;
        w_best_key = r_item.key;
        if (w_rdata_a.key < r_item.key) begin
            w_take_l   = 1'b1;
            w_best_key = w_rdata_a.key;
        end
        if ((w_rc < w_count_l) && (w_rdata_b.key < w_best_key)) begin
            w_take_l = 1'b0;
            w_take_r = 1'b1;
        end
    end

    // sift sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_item      = r_item;
        n_res_valid = r_res_valid;
        n_res       = r_res;
        n_res_drop  = r_res_drop;
        n_out_full  = r_out_full && !o_out.ready;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_out_drop  = r_out_drop;
        n_out_occ   = r_out_occ;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_item;
        w_raddr_a   = w_parent;
        w_raddr_b   = AW'(r_count);

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_valid = 1'b0;
                    n_res       = '0;
                    n_res_drop  = 1'b0;
                    n_item      = '{key: i_in.entry_key, tag: i_in.entry_tag};
                    if (i_in.action == ACT_INSERT) begin
                        if (r_count == CW'(HEAP_DEPTH)) begin
                            n_res_drop = 1'b1;
                            n_state    = S_FIN;
                        end else begin
                            n_pos   = AW'(r_count);
                            n_count = CW'(r_count + CW'(1));
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_state = S_FIN;
                        end else begin
                            // fetch root and last slot
                            w_raddr_a = '0;
                            w_raddr_b = AW'(r_count - CW'(1));
                            n_count   = CW'(r_count - CW'(1));
                            n_state   = S_DN_ROOT;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_raddr_a = w_parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (r_item.key < w_rdata_a.key) begin
                    // parent moves down into the hole
                    w_wdata = w_rdata_a;
                    n_pos   = w_parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_ROOT: begin
                n_res_valid = 1'b1;
                n_res       = w_rdata_a;
                n_item      = w_rdata_b;
                n_pos       = '0;
                n_state     = S_DN_RD;
            end
            S_DN_RD: begin
                if (w_lc < w_count_l) begin
                    w_raddr_a = AW'(w_lc);
                    w_raddr_b = AW'(w_rc);
                    n_state   = S_DN_CMP;
                end else begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_take_l) begin
                    w_wdata = w_rdata_a;
                    n_pos   = AW'(w_lc);
                    n_state = S_DN_RD;
                end else if (w_take_r) begin
                    w_wdata = w_rdata_b;
                    n_pos   = AW'(w_rc);
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hand the result to the output register when it is free
                if (!r_out_full || o_out.ready) begin
                    n_out_full  = 1'b1;
                    n_out_valid = r_res_valid;
                    n_out       = r_res;
                    n_out_drop  = r_res_drop;
                    n_out_occ   = OCC_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_out_full <= n_out_full;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_item      <= n_item;
        r_res_valid <= n_res_valid;
        r_res       <= n_res;
        r_res_drop  <= n_res_drop;
        r_out_valid <= n_out_valid;
        r_out       <= n_out;
        r_out_drop  <= n_out_drop;
        r_out_occ   <= n_out_occ;
    end

    // response channel
    assign o_out.valid     = r_out_full;
    assign o_out.out_valid = r_out_valid;
    assign o_out.out_key   = r_out.key;
    assign o_out.out_tag   = r_out.tag;
    assign o_out.dropped   = r_out_drop;
    assign o_out.occupancy = r_out_occ;

endmodule
